@@ design/rau_pkg.sv @@
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;

  // Operation codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Which product the shared multiplier forms in a given cycle.
  typedef enum logic [1:0] {
    MS_P1  = 2'd0,
    MS_P2  = 2'd1,
    MS_DEN = 2'd2
  } mul_sel_e;

  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 30;

  localparam logic [RES_NUM_W-2:0] NUM_MAX_OUT = '1;
  localparam logic [RES_DEN_W-1:0] DEN_MAX_OUT = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     comb;
    logic     gcd_step;
    logic     gcd_fin;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_last;
  } sts_t;

endpackage

@@ design/rau_ctrl.sv @@
// Sequencing state machine and output handshake of the rational arithmetic unit.
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rau_pkg::cmd_t cmd_o,
  input  rau_pkg::sts_t sts_i
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MUL_P1  = 8'b0000_0010,
    ST_MUL_P2  = 8'b0000_0100,
    ST_MUL_DEN = 8'b0000_1000,
    ST_COMB    = 8'b0001_0000,
    ST_GCD     = 8'b0010_0000,
    ST_DIV     = 8'b0100_0000,
    ST_FIN     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.mul_en   = 1'b0;
    cmd_o.mul_sel  = rau_pkg::MS_P1;
    cmd_o.comb     = 1'b0;
    cmd_o.gcd_step = 1'b0;
    cmd_o.gcd_fin  = 1'b0;
    cmd_o.div_step = 1'b0;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MUL_P1;
        end
      end
      ST_MUL_P1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MS_P1;
        state_d       = ST_MUL_P2;
      end
      ST_MUL_P2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MS_P2;
        state_d       = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MS_DEN;
        state_d       = ST_COMB;
      end
      ST_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = sts_i.special ? ST_FIN : ST_GCD;
      end
      ST_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.gcd_fin = 1'b1;
          state_d       = ST_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/rau_dp.sv @@
// Datapath of the rational arithmetic unit: multiplier, binary gcd and two-lane divider.
module rau_dp #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                               clk_i,
  input  rau_pkg::cmd_t                      cmd_i,
  output rau_pkg::sts_t                      sts_o,
  input  logic [1:0]                         operation_i,
  input  logic signed [OPERAND_BITS-1:0]     a_num_i,
  input  logic [OPERAND_BITS-2:0]            a_den_i,
  input  logic signed [OPERAND_BITS-1:0]     b_num_i,
  input  logic [OPERAND_BITS-2:0]            b_den_i,
  output logic signed [rau_pkg::RES_NUM_W-1:0] res_num_o,
  output logic [rau_pkg::RES_DEN_W-1:0]      res_den_o,
  output logic                               div_zero_o
);

  localparam int W    = OPERAND_BITS;
  localparam int PW   = 2 * W;
  localparam int MW   = 2 * W - 1;
  localparam int CW   = (MW > rau_pkg::RES_NUM_W) ? MW : rau_pkg::RES_NUM_W;
  localparam int KW   = $clog2(MW + 1);
  localparam int CNTW = $clog2(MW);

  rau_pkg::op_e      op_q;
  logic [W-1:0]      an_q, bn_q;
  logic [W-2:0]      ad_q, bd_q;
  logic              err_q;
  logic [PW-1:0]     p1_q, p2_q, pd_q;
  logic              neg_q, special_q;
  logic [MW-1:0]     un_q, ud_q, x_q, y_q, g_q, rn_q, rd_q;
  logic [KW-1:0]     k_q;
  logic [CNTW-1:0]   cnt_q;
  logic signed [rau_pkg::RES_NUM_W-1:0] res_num_q;
  logic [rau_pkg::RES_DEN_W-1:0]        res_den_q;
  logic              div_zero_q;

  logic signed [W:0]    ma, mb;
  logic signed [PW+1:0] prod;
  logic [PW-1:0]        nsum, nmag, dmag;
  logic                 n_zero, in_err;
  logic [MW-1:0]        g_new;
  logic [MW:0]          rsn, rsd, dfn, dfd;
  logic                 gen, ged;
  logic [CW-1:0]        numc, denc;
  logic [rau_pkg::RES_NUM_W-2:0] num_mag;
  logic [rau_pkg::RES_DEN_W-1:0] den_sat;
  logic signed [rau_pkg::RES_NUM_W-1:0] num_out;

  // A zero denominator is treated like a division by zero.
  assign in_err = (a_den_i == '0) || (b_den_i == '0) ||
                  ((rau_pkg::op_e'(operation_i) == rau_pkg::OP_DIV) && (b_num_i == '0));

  // Operand selection for the single shared multiplier.
  always_comb begin
    ma = {an_q[W-1], an_q};
    mb = {2'b00, bd_q};
    case (cmd_i.mul_sel)
      rau_pkg::MS_P1: begin
        ma = {an_q[W-1], an_q};
        mb = (op_q == rau_pkg::OP_MUL) ? {bn_q[W-1], bn_q} : {2'b00, bd_q};
      end
      rau_pkg::MS_P2: begin
        ma = {2'b00, ad_q};
        mb = {bn_q[W-1], bn_q};
      end
      rau_pkg::MS_DEN: begin
        ma = {2'b00, ad_q};
        mb = (op_q == rau_pkg::OP_DIV) ? {bn_q[W-1], bn_q} : {2'b00, bd_q};
      end
      default: begin
        ma = {an_q[W-1], an_q};
        mb = {2'b00, bd_q};
      end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    case (op_q)
      rau_pkg::OP_ADD: nsum = p1_q + p2_q;
      rau_pkg::OP_SUB: nsum = p1_q - p2_q;
      default:         nsum = p1_q;
    endcase
    n_zero = (nsum == '0);
    nmag   = nsum[PW-1] ? (~nsum + PW'(1)) : nsum;
    dmag   = pd_q[PW-1] ? (~pd_q + PW'(1)) : pd_q;
  end

  // Both gcd operands are nonzero at the start, so one of them reaches zero first.
  assign g_new = (x_q | y_q) << k_q;

  // One restoring quotient bit per cycle in each lane.
  always_comb begin
    rsn = {rn_q, un_q[MW-1]};
    rsd = {rd_q, ud_q[MW-1]};
    dfn = rsn - {1'b0, g_q};
    dfd = rsd - {1'b0, g_q};
    gen = (rsn >= {1'b0, g_q});
    ged = (rsd >= {1'b0, g_q});
  end

  // Saturate each reduced part on its own, then apply the sign.
  always_comb begin
    numc    = CW'(un_q);
    denc    = CW'(ud_q);
    num_mag = (numc > CW'(rau_pkg::NUM_MAX_OUT)) ? rau_pkg::NUM_MAX_OUT
                                                  : numc[rau_pkg::RES_NUM_W-2:0];
    den_sat = (denc > CW'(rau_pkg::DEN_MAX_OUT)) ? rau_pkg::DEN_MAX_OUT
                                                  : denc[rau_pkg::RES_DEN_W-1:0];
    num_out = neg_q ? -$signed({1'b0, num_mag}) : $signed({1'b0, num_mag});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= rau_pkg::op_e'(operation_i);
      an_q  <= a_num_i;
      ad_q  <= a_den_i;
      bn_q  <= b_num_i;
      bd_q  <= b_den_i;
      err_q <= in_err;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        rau_pkg::MS_P1:  p1_q <= prod[PW-1:0];
        rau_pkg::MS_P2:  p2_q <= prod[PW-1:0];
        default:         pd_q <= prod[PW-1:0];
      endcase
    end
    if (cmd_i.comb) begin
      special_q <= err_q || n_zero;
      neg_q     <= nsum[PW-1] ^ pd_q[PW-1];
      un_q      <= nmag[MW-1:0];
      ud_q      <= dmag[MW-1:0];
      x_q       <= nmag[MW-1:0];
      y_q       <= dmag[MW-1:0];
      k_q       <= '0;
    end
    if (cmd_i.gcd_step) begin
      if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
    if (cmd_i.gcd_fin) begin
      g_q   <= g_new;
      rn_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rn_q  <= gen ? dfn[MW-1:0] : rsn[MW-1:0];
      rd_q  <= ged ? dfd[MW-1:0] : rsd[MW-1:0];
      un_q  <= {un_q[MW-2:0], gen};
      ud_q  <= {ud_q[MW-2:0], ged};
      cnt_q <= cnt_q + CNTW'(1);
    end
    if (cmd_i.out_load) begin
      if (special_q) begin
        res_num_q  <= '0;
        res_den_q  <= rau_pkg::RES_DEN_W'(1);
        div_zero_q <= err_q;
      end else begin
        res_num_q  <= num_out;
        res_den_q  <= den_sat;
        div_zero_q <= 1'b0;
      end
    end
  end

  assign sts_o.special  = err_q || n_zero;
  assign sts_o.gcd_done = (x_q == '0) || (y_q == '0);
  assign sts_o.div_last = (cnt_q == CNTW'(MW - 1));

  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign div_zero_o = div_zero_q;

endmodule

@@ design/rational_arith_unit.sv @@
// Top level of the rational arithmetic unit: fraction add, subtract, multiply, divide.
//
//  channel  direction  handshake                 payload
//  input    in         in_valid_i / in_stall_o   operation_i, a_num_i, a_den_i, b_num_i, b_den_i
//  result   out        out_valid_o / out_stall_i res_num_o, res_den_o, div_zero_o
//
// One beat is worked on at a time. Three products on the shared multiplier and a combine
// step, then a binary gcd (data dependent) and the two-lane restoring divider, which
// forms 2*OPERAND_BITS-1 quotient bits per lane. Error and zero results skip the gcd
// and the divider and go from the combine step to the output register.
// Reset clears the controller only; nothing needs clearing after it.
// A finished result waits in the output register, and the next input beat is taken
// while it is stalled there.
module rational_arith_unit #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           operation_i,
  input  logic signed [OPERAND_BITS-1:0]       a_num_i,
  input  logic [OPERAND_BITS-2:0]              a_den_i,
  input  logic signed [OPERAND_BITS-1:0]       b_num_i,
  input  logic [OPERAND_BITS-2:0]              b_den_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rau_pkg::RES_NUM_W-1:0] res_num_o,
  output logic [rau_pkg::RES_DEN_W-1:0]        res_den_o,
  output logic                                 div_zero_o
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rau_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .div_zero_o  (div_zero_o)
  );

endmodule

@@ design/rau_checker.sv @@
// Port-level checks of the rational arithmetic unit and their binding to the top level.
module rau_checker #(
  parameter int OPERAND_BITS = 16
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [1:0]                           operation_i,
  input logic signed [OPERAND_BITS-1:0]       a_num_i,
  input logic [OPERAND_BITS-2:0]              a_den_i,
  input logic signed [OPERAND_BITS-1:0]       b_num_i,
  input logic [OPERAND_BITS-2:0]              b_den_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [rau_pkg::RES_NUM_W-1:0] res_num_o,
  input logic [rau_pkg::RES_DEN_W-1:0]        res_den_o,
  input logic                                 div_zero_o
);

  logic in_beat;
  logic in_any;

  assign in_beat = in_valid_i && !in_stall_o;
  // Payload is only watched so that every port of the top level is seen here.
  assign in_any  = (operation_i != '0) || (a_num_i != '0) || (a_den_i != '0) ||
                   (b_num_i != '0) || (b_den_i != '0);

  // A stalled result beat stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_num_o) &&
    $stable(res_den_o) && $stable(div_zero_o))
    else $error("result beat changed while stalled");

  // The unit stays busy into the multiply phase after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too early");

  // An error result is always zero over one.
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> (res_num_o == '0) && (res_den_o == 1))
    else $error("error result is not 0/1");

  // A result denominator is never zero, and a zero numerator comes with denominator one.
  a_den_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (in_any || !in_any) |-> (res_den_o != '0) &&
    ((res_num_o != '0) || (res_den_o == 1)))
    else $error("result denominator malformed");

endmodule

bind rational_arith_unit rau_checker #(.OPERAND_BITS(OPERAND_BITS)) u_rau_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for the fraction add, subtract, multiply and divide unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPW          = 16;
  localparam int DENW         = OPW - 1;
  localparam int NUM_TOP      = (1 << (OPW - 1)) - 1;
  localparam int DEN_TOP      = (1 << DENW) - 1;
  localparam int RANDOM_ITEMS = 650;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [rau_pkg::RES_NUM_W-1:0] num;
    logic [rau_pkg::RES_DEN_W-1:0]        den;
    logic                                 dz;
  } fraction_t;

  typedef struct packed {
    rau_pkg::op_e           op;
    logic signed [OPW-1:0]  an;
    logic [DENW-1:0]        ad;
    logic signed [OPW-1:0]  bn;
    logic [DENW-1:0]        bd;
    logic                   known;
    fraction_t              want;
  } stim_row_t;

  localparam int N_DIRECTED = 23;
  // Rows with known set carry a result that can be read off directly.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{rau_pkg::OP_ADD, 0, 1, 0, 1, 1'b1, '{0, 1, 1'b0}},
    '{rau_pkg::OP_DIV, 5, 3, 0, 7, 1'b1, '{0, 1, 1'b1}},
    '{rau_pkg::OP_ADD, 1, 0, 1, 1, 1'b1, '{0, 1, 1'b1}},
    '{rau_pkg::OP_MUL, 3, 4, 5, 0, 1'b1, '{0, 1, 1'b1}},
    '{rau_pkg::OP_DIV, 9, 0, 0, 3, 1'b1, '{0, 1, 1'b1}},
    '{rau_pkg::OP_MUL, -32768, 1, -32768, 1, 1'b1, '{1073741824, 1, 1'b0}},
    '{rau_pkg::OP_MUL, 32767, 1, 32767, 1, 1'b1, '{1073676289, 1, 1'b0}},
    '{rau_pkg::OP_MUL, 1, 32767, 1, 32767, 1'b1, '{1, 1073676289, 1'b0}},
    '{rau_pkg::OP_ADD, -32768, 1, -32768, 1, 1'b1, '{-65536, 1, 1'b0}},
    '{rau_pkg::OP_SUB, 32767, 1, -32768, 1, 1'b1, '{65535, 1, 1'b0}},
    '{rau_pkg::OP_DIV, -32768, 1, 1, 32767, 1'b1, '{-1073709056, 1, 1'b0}},
    '{rau_pkg::OP_DIV, 1, 1, -1, 1, 1'b1, '{-1, 1, 1'b0}},
    '{rau_pkg::OP_DIV, -3, 4, -3, 4, 1'b1, '{1, 1, 1'b0}},
    '{rau_pkg::OP_SUB, 7, 9, 7, 9, 1'b1, '{0, 1, 1'b0}},
    '{rau_pkg::OP_MUL, 0, 5, 3, 4, 1'b1, '{0, 1, 1'b0}},
    '{rau_pkg::OP_DIV, 0, 5, 3, 4, 1'b1, '{0, 1, 1'b0}},
    '{rau_pkg::OP_DIV, 32767, 1, 1, 32767, 1'b1, '{1073676289, 1, 1'b0}},
    '{rau_pkg::OP_ADD, 1, 2, 1, 3, 1'b0, '{0, 0, 1'b0}},
    '{rau_pkg::OP_SUB, 1, 6, 1, 3, 1'b0, '{0, 0, 1'b0}},
    '{rau_pkg::OP_MUL, -32767, 32767, 32767, 2, 1'b0, '{0, 0, 1'b0}},
    '{rau_pkg::OP_DIV, 12345, 32767, -32768, 16384, 1'b0, '{0, 0, 1'b0}},
    '{rau_pkg::OP_ADD, -32768, 32767, -32768, 32767, 1'b0, '{0, 0, 1'b0}},
    '{rau_pkg::OP_SUB, 1, 32767, -1, 32766, 1'b0, '{0, 0, 1'b0}}
  };

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic [1:0]                           operation_i;
  logic signed [OPW-1:0]                a_num_i;
  logic [DENW-1:0]                      a_den_i;
  logic signed [OPW-1:0]                b_num_i;
  logic [DENW-1:0]                      b_den_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic signed [rau_pkg::RES_NUM_W-1:0] res_num_o;
  logic [rau_pkg::RES_DEN_W-1:0]        res_den_o;
  logic                                 div_zero_o;

  fraction_t awaited_fractions[$];
  int        mismatches   = 0;
  int        results_seen = 0;
  int        burst_left   = 0;

  rational_arith_unit #(
    .OPERAND_BITS(OPW)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .div_zero_o  (div_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact fraction arithmetic, reduced by the gcd of the magnitudes and saturated per part.
  function automatic fraction_t predict_fraction(rau_pkg::op_e op,
                                                 logic signed [OPW-1:0] an,
                                                 logic [DENW-1:0] ad,
                                                 logic signed [OPW-1:0] bn,
                                                 logic [DENW-1:0] bd);
    longint          xan, xad, xbn, xbd, n, d;
    longint unsigned un, ud, x, y, r;
    logic            neg;
    fraction_t       f;
    f = '{num: '0, den: 1, dz: 1'b0};
    xan = an;
    xad = ad;
    xbn = bn;
    xbd = bd;
    if (xad == 0 || xbd == 0 || (op == rau_pkg::OP_DIV && xbn == 0)) begin
      f.dz = 1'b1;
      return f;
    end
    case (op)
      rau_pkg::OP_ADD: begin n = xan * xbd + xad * xbn; d = xad * xbd; end
      rau_pkg::OP_SUB: begin n = xan * xbd - xad * xbn; d = xad * xbd; end
      rau_pkg::OP_MUL: begin n = xan * xbn;             d = xad * xbd; end
      default: begin n = xan * xbd;                     d = xad * xbn; end
    endcase
    if (n == 0) return f;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    x = un;
    y = ud;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    un = un / x;
    ud = ud / x;
    if (un > 64'd2147483647) un = 64'd2147483647;
    if (ud > 64'd1073741823) ud = 64'd1073741823;
    f.num = neg ? -un[rau_pkg::RES_NUM_W-1:0] : un[rau_pkg::RES_NUM_W-1:0];
    f.den = ud[rau_pkg::RES_DEN_W-1:0];
    return f;
  endfunction

  function automatic logic signed [OPW-1:0] rand_numerator();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6: v = int'($urandom_range(0, 40)) - 20;
      7: begin
        case ($urandom_range(0, 3))
          0: v = -NUM_TOP - 1;
          1: v = NUM_TOP;
          2: v = -NUM_TOP;
          default: v = -1;
        endcase
      end
      8: v = 0;
      default: begin
        // Products of small factors leave a large common divisor to remove.
        v = $urandom_range(1, 120) * $urandom_range(1, 250);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v[OPW-1:0];
  endfunction

  function automatic logic [DENW-1:0] rand_denominator();
    int sel, v;
    sel = $urandom_range(0, 49);
    if (sel == 0) v = 0;
    else if (sel < 4) v = DEN_TOP;
    else if (sel < 20) v = $urandom_range(1, 30);
    else if (sel < 30) v = $urandom_range(1, 120) * $urandom_range(1, 250);
    else v = $urandom_range(1, DEN_TOP);
    return v[DENW-1:0];
  endfunction

  // Presents one beat at a falling edge, holds it until taken, and queues its result.
  task automatic offer_fraction(rau_pkg::op_e op, logic signed [OPW-1:0] an,
                                logic [DENW-1:0] ad,
                                logic signed [OPW-1:0] bn, logic [DENW-1:0] bd,
                                logic known, fraction_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i  <= 1'b0;
        operation_i <= $urandom;
        a_num_i     <= $urandom;
        a_den_i     <= $urandom;
        b_num_i     <= $urandom;
        b_den_i     <= $urandom;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    operation_i <= op;
    a_num_i     <= an;
    a_den_i     <= ad;
    b_num_i     <= bn;
    b_den_i     <= bd;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    awaited_fractions.push_back(known ? want : predict_fraction(op, an, ad, bn, bd));
    @(negedge clk_i);
  endtask

  initial begin
    in_valid_i  = 1'b0;
    operation_i = '0;
    a_num_i     = '0;
    a_den_i     = '0;
    b_num_i     = '0;
    b_den_i     = '0;
    rst_ni      = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DIRECTED[i]) begin
      offer_fraction(DIRECTED[i].op, DIRECTED[i].an, DIRECTED[i].ad, DIRECTED[i].bn,
                     DIRECTED[i].bd, DIRECTED[i].known, DIRECTED[i].want);
    end
    repeat (RANDOM_ITEMS) begin
      offer_fraction(rau_pkg::op_e'($urandom_range(0, 3)), rand_numerator(),
                     rand_denominator(), rand_numerator(), rand_denominator(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (awaited_fractions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: open stretches, short choppy stalls, and one long hold-off that backs
  // the unit up until it stalls its input.
  initial begin
    int   k;
    logic v;
    logic held_off;
    held_off    = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held_off && results_seen >= 60) begin
        held_off = 1'b1;
        v = 1'b1;
        k = LONG_HOLD;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin v = 1'b0; k = $urandom_range(50, 300); end
          2: begin v = 1'b1; k = $urandom_range(1, 12); end
          default: begin v = $urandom_range(0, 1); k = $urandom_range(1, 6); end
        endcase
      end
      out_stall_i <= v;
      repeat (k) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_fractions.size() == 0) begin
        $display("%0t: result %0d/%0d div_zero %0b arrived with none outstanding",
                 $time, res_num_o, res_den_o, div_zero_o);
        mismatches++;
      end else begin
        want = awaited_fractions.pop_front();
        if (res_num_o !== want.num) begin
          $display("%0t: res_num expected %0d, got %0d", $time, want.num, res_num_o);
          mismatches++;
        end
        if (res_den_o !== want.den) begin
          $display("%0t: res_den expected %0d, got %0d", $time, want.den, res_den_o);
          mismatches++;
        end
        if (div_zero_o !== want.dz) begin
          $display("%0t: div_zero expected %0b, got %0b", $time, want.dz, div_zero_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
